/* rtl/core/sm3_pkg.sv */
`timescale 1ns / 1ps

package sm3_pkg;

  localparam logic [31:0] T_LOW    = 32'h79CC4519;
  localparam logic [31:0] T_HIGH   = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int unsigned CNT_W    = 55;

  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] FILL_LEN  = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_PAD80,
    ST_PADZ,
    ST_LEN,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } sm3_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_APPEND,
    OP_PAD80,
    OP_PADZ,
    OP_LEN,
    OP_ROUND,
    OP_FOLD,
    OP_EMIT
  } sm3_op_e;

  typedef struct packed {
    logic [5:0] fill;
    logic       rem_zero;
    logic       last;
    logic       round_last;
    logic       out_last;
  } sm3_status_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] r;
    unique case (idx)
      3'd0: r = 32'h7380166F;
      3'd1: r = 32'h4914B2B9;
      3'd2: r = 32'h172442D7;
      3'd3: r = 32'hDA8A0600;
      3'd4: r = 32'hA96F30BC;
      3'd5: r = 32'h163138AA;
      3'd6: r = 32'hE38DEE4D;
      default: r = 32'hB0FB0E4E;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

/* rtl/core/sm3_hash_engine.sv */
`timescale 1ns / 1ps
// input: a word is taken only in idle; its valid bytes are then appended one at a time
// each full 64-byte block runs 64 rounds of one shared round unit and then a fold
// last word: padding runs one byte a cycle except while a block compresses, then
// eight digest words go out, one per handshake
// reset: asynchronous, active low; chaining value returns to the iv, counts clear

module sm3_hash_engine
  import sm3_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] msg_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        digest_done_o
);

  sm3_status_t status;
  sm3_op_e     op;

  sm3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .op_o        (op)
  );

  sm3_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .msg_word_i    (msg_word_i),
    .valid_bytes_i (valid_bytes_i),
    .last_word_i   (last_word_i),
    .status_o      (status),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o)
  );

  assign digest_done_o = (word_index_o == 3'd7);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input and output open together");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("ready right after accept");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && digest_done_o) |=> (!out_valid_o && in_ready_o))
    else $error("digest did not close");

endmodule

/* rtl/core/sm3_ctrl.sv */
`timescale 1ns / 1ps

module sm3_ctrl
  import sm3_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  sm3_status_t status_i,
  output sm3_op_e     op_o
);

  sm3_state_e state_q, state_d;
  sm3_state_e ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_APPEND;
      end
      ST_APPEND: begin
        if (status_i.rem_zero) begin
          state_d = status_i.last ? ST_PAD80 : ST_IDLE;
        end else if (status_i.fill == FILL_LAST) begin
          state_d = ST_COMP;
          ret_d   = ST_APPEND;
        end
      end
      ST_PAD80: begin
        state_d = ST_PADZ;
        if (status_i.fill == FILL_LAST) begin
          state_d = ST_COMP;
          ret_d   = ST_PADZ;
        end
      end
      ST_PADZ: begin
        if (status_i.fill == FILL_LEN) begin
          state_d = ST_LEN;
        end else if (status_i.fill == FILL_LAST) begin
          state_d = ST_COMP;
          ret_d   = ST_PADZ;
        end
      end
      ST_LEN: begin
        if (status_i.fill == FILL_LAST) begin
          state_d = ST_COMP;
          ret_d   = ST_OUT;
        end
      end
      ST_COMP: begin
        if (status_i.round_last) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        state_d = ret_q;
      end
      ST_OUT: begin
        if (out_ready_i && status_i.out_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    op_o        = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = OP_LOAD;
      end
      ST_APPEND: begin
        if (!status_i.rem_zero) op_o = OP_APPEND;
      end
      ST_PAD80: op_o = OP_PAD80;
      ST_PADZ: begin
        if (status_i.fill != FILL_LEN) op_o = OP_PADZ;
      end
      ST_LEN:  op_o = OP_LEN;
      ST_COMP: op_o = OP_ROUND;
      ST_FOLD: op_o = OP_FOLD;
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) op_o = OP_EMIT;
      end
      default: op_o = OP_NONE;
    endcase
  end

endmodule

/* rtl/core/sm3_dp.sv */
`timescale 1ns / 1ps

module sm3_dp
  import sm3_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sm3_op_e     op_i,
  input  logic [31:0] msg_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        last_word_i,
  output sm3_status_t status_o,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o
);

  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
  logic [5:0]  fill_q, j_q;
  logic [CNT_W-1:0] cnt_q;
  logic [63:0] len_q;
  logic [31:0] hold_q;
  logic [2:0]  rem_q;
  logic        last_q;
  logic [2:0]  idx_q;

  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [3:0]  wr_idx;
  logic [1:0]  wr_lane;

  logic [31:0] tj, ff, gg, a12, ss1, ss2, tt1, tt2, w_new;

  always_comb begin
    wr_en   = 1'b0;
    wr_byte = 8'h00;
    unique case (op_i)
      OP_APPEND: begin wr_en = 1'b1; wr_byte = hold_q[31:24]; end
      OP_PAD80:  begin wr_en = 1'b1; wr_byte = PAD_BYTE;      end
      OP_PADZ:   begin wr_en = 1'b1; wr_byte = 8'h00;         end
      OP_LEN:    begin wr_en = 1'b1; wr_byte = len_q[63:56];  end
      default:   begin wr_en = 1'b0; wr_byte = 8'h00;         end
    endcase
  end

  assign wr_idx  = fill_q[5:2];
  assign wr_lane = 2'd3 - fill_q[1:0];

  always_comb begin
    tj  = rotl((j_q < 6'd16) ? T_LOW : T_HIGH, j_q[4:0]);
    ff  = (j_q < 6'd16) ? (a_q ^ b_q ^ c_q) : ((a_q & b_q) | (a_q & c_q) | (b_q & c_q));
    gg  = (j_q < 6'd16) ? (e_q ^ f_q ^ g_q) : ((e_q & f_q) | (~e_q & g_q));
    a12 = rotl(a_q, 5'd12);
    ss1 = rotl(a12 + e_q + tj, 5'd7);
    ss2 = ss1 ^ a12;
    tt1 = ff + d_q + ss2 + (w_q[0] ^ w_q[4]);
    tt2 = gg + h_q + ss1 + w_q[0];
    w_new = perm1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15))
            ^ rotl(w_q[3], 5'd7) ^ w_q[10];
  end

  // message window: byte writes while filling, shifts during rounds
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      w_q[wr_idx][wr_lane*8 +: 8] <= wr_byte;
    end else if (op_i == OP_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && fill_q == FILL_LAST) begin
      a_q <= v_q[0]; b_q <= v_q[1]; c_q <= v_q[2]; d_q <= v_q[3];
      e_q <= v_q[4]; f_q <= v_q[5]; g_q <= v_q[6]; h_q <= v_q[7];
    end else if (op_i == OP_ROUND) begin
      d_q <= c_q;
      c_q <= rotl(b_q, 5'd9);
      b_q <= a_q;
      a_q <= tt1;
      h_q <= g_q;
      g_q <= rotl(f_q, 5'd19);
      f_q <= e_q;
      e_q <= perm0(tt2);
    end
    if (op_i == OP_LOAD) hold_q <= msg_word_i;
    else if (op_i == OP_APPEND) hold_q <= {hold_q[23:0], 8'h00};
    if (op_i == OP_PAD80) len_q <= {cnt_q, fill_q, 3'b000};
    else if (op_i == OP_LEN) len_q <= {len_q[55:0], 8'h00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) v_q[i] <= iv_word(3'(i));
      fill_q <= '0;
      j_q    <= '0;
      cnt_q  <= '0;
      rem_q  <= '0;
      last_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (wr_en) fill_q <= fill_q + 6'd1;
      if (wr_en && fill_q == FILL_LAST) j_q <= '0;
      else if (op_i == OP_ROUND) j_q <= j_q + 6'd1;
      if (op_i == OP_LOAD) begin
        rem_q  <= (valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;
        last_q <= last_word_i;
      end else if (op_i == OP_APPEND) begin
        rem_q <= rem_q - 3'd1;
      end
      if (op_i == OP_FOLD) begin
        v_q[0] <= v_q[0] ^ a_q; v_q[1] <= v_q[1] ^ b_q;
        v_q[2] <= v_q[2] ^ c_q; v_q[3] <= v_q[3] ^ d_q;
        v_q[4] <= v_q[4] ^ e_q; v_q[5] <= v_q[5] ^ f_q;
        v_q[6] <= v_q[6] ^ g_q; v_q[7] <= v_q[7] ^ h_q;
        cnt_q  <= cnt_q + CNT_W'(1);
      end
      if (op_i == OP_EMIT) begin
        idx_q <= idx_q + 3'd1;
        if (idx_q == 3'd7) begin
          for (int i = 0; i < 8; i++) v_q[i] <= iv_word(3'(i));
          fill_q <= '0;
          cnt_q  <= '0;
        end
      end
    end
  end

  assign status_o.fill       = fill_q;
  assign status_o.rem_zero   = (rem_q == 3'd0);
  assign status_o.last       = last_q;
  assign status_o.round_last = (j_q == 6'd63);
  assign status_o.out_last   = (idx_q == 3'd7);

  assign digest_word_o = v_q[idx_q];
  assign word_index_o  = idx_q;

endmodule
